// File: rtl/core/sacrr_pkg.sv
// Shared constants, payload types and helpers of the set-associative cache.
package sacrr_pkg;

  localparam int SET_BITS   = 6;
  localparam int WAY_BITS   = 2;
  localparam int BLOCK_BITS = 6;
  localparam int ADDR_BITS  = 32;

  localparam int NSETS      = 1 << SET_BITS;
  localparam int NWAYS      = 1 << WAY_BITS;
  localparam int WORD_BITS  = BLOCK_BITS - 2;
  localparam int NWORDS     = 1 << WORD_BITS;
  localparam int TAG_BITS   = ADDR_BITS - SET_BITS - BLOCK_BITS;
  localparam int LINE_BITS  = SET_BITS + WAY_BITS;
  localparam int DADDR_BITS = LINE_BITS + WORD_BITS;

  localparam logic [31:0] WORD_ALIGN = 32'h3;
  localparam logic [31:0] ADDR_MASK  = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0] BLOCK_MASK = 32'((64'd1 << BLOCK_BITS) - 64'd1);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_MEMW  = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [1:0]  victim_way;
    logic [31:0] fill_data;
  } in_pay_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [31:0] address;
    logic [31:0] data;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_pay_t;

  function automatic logic [31:0] merge_word(logic [31:0] old_w, logic [31:0] new_w,
                                             logic [31:0] mask);
    return (old_w & ~mask) | (new_w & mask);
  endfunction

endpackage

// File: rtl/core/sacrr_if.sv
// Valid/ready channel interfaces for the request and result sides of the cache.
interface sacrr_in_if import sacrr_pkg::*; ();
  logic    valid;
  logic    ready;
  in_pay_t pay;
  modport source (output valid, output pay, input ready);
  modport sink (input valid, input pay, output ready);
endinterface

interface sacrr_out_if import sacrr_pkg::*; ();
  logic     valid;
  logic     ready;
  out_pay_t pay;
  modport source (output valid, output pay, input ready);
  modport sink (input valid, input pay, output ready);
endinterface

// File: rtl/core/sacrr_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module sacrr_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [(1 << AW)];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/set_assoc_cache_random_replace_core.sv
// Top level of the set-associative write-back cache with caller-chosen replacement.
// A request is accepted only while idle. A hit reads the tag row, then the data word,
// then registers its result. A miss takes the lowest invalid way, else the caller's
// victim, emits a dirty victim word by word, then emits the fetch request. Fill words
// are accepted back to back; after the final one the requested word is read and its
// result registered, while a write miss merges the write, writes the whole block back
// and then emits its result. Output stalls hold each state that emits a result. The
// data RAM has one registered read port. Reset (synchronous, active low) clears all
// valid and dirty bits, counters and pending state at once; no clearing pass.
module set_assoc_cache_random_replace_core import sacrr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sacrr_in_if.sink   in_req,
  sacrr_out_if.source out_rsp
);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TAG   = 9'b000000010,
    S_HIT   = 9'b000000100,
    S_EVRD  = 9'b000001000,
    S_EVOUT = 9'b000010000,
    S_FETCH = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FOUT  = 9'b010000000,
    S_WDONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Access being worked on; while a fill is pending it is the pending access.
  logic                 req_wr_r, req_wr_nxt;
  logic [31:0]          req_addr_r, req_addr_nxt;
  logic [31:0]          req_wd_r, req_wd_nxt;
  logic [31:0]          req_wm_r, req_wm_nxt;
  logic [WAY_BITS-1:0]  req_vw_r, req_vw_nxt;
  logic                 pend_r, pend_nxt;
  logic [WORD_BITS-1:0] fill_idx_r, fill_idx_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [31:0]          base_r, base_nxt;
  logic [WORD_BITS-1:0] widx_r, widx_nxt;
  logic                 blk_fill_r, blk_fill_nxt;
  logic [31:0]          hit_cnt_r, hit_cnt_nxt;
  logic [31:0]          miss_cnt_r, miss_cnt_nxt;

  // Valid and dirty bits live in flops so that reset clears them at once.
  logic [NSETS-1:0][NWAYS-1:0] valid_r, valid_nxt;
  logic [NSETS-1:0][NWAYS-1:0] dirty_r, dirty_nxt;

  // Tag memory: one row per set, read as a whole row, written one way at a time.
  logic [TAG_BITS-1:0]              tag_mem [NSETS][NWAYS];
  logic [NWAYS-1:0][TAG_BITS-1:0]   tag_row_r;
  logic                             tag_re;
  logic [SET_BITS-1:0]              tag_rset;
  logic                             tag_we;
  logic [WAY_BITS-1:0]              tag_wway;

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  out_pay_t out_r, out_nxt;
  logic     emit;
  out_pay_t emit_pay;
  logic     slot_free;

  // Data RAM controls.
  logic                  ram_we, ram_re;
  logic [DADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [31:0]           ram_wdata, ram_rdata;

  // Lookup decode.
  logic [SET_BITS-1:0]  req_set;
  logic [TAG_BITS-1:0]  req_tag;
  logic [WORD_BITS-1:0] req_word;
  logic [NWAYS-1:0]     hit_vec;
  logic [NWAYS-1:0]     inv_vec;
  logic [WAY_BITS-1:0]  hit_way, inv_way, vic_way;
  logic [31:0]          in_addr;

  assign req_set  = req_addr_r[BLOCK_BITS +: SET_BITS];
  assign req_tag  = req_addr_r[SET_BITS + BLOCK_BITS +: TAG_BITS];
  assign req_word = req_addr_r[2 +: WORD_BITS];
  assign in_addr  = in_req.pay.addr & ADDR_MASK & ~WORD_ALIGN;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < NWAYS; w++) begin
      hit_vec[w] = valid_r[req_set][w] && (tag_row_r[w] == req_tag);
      inv_vec[w] = !valid_r[req_set][w];
    end
    // Lowest way wins in both searches.
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_BITS'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_BITS'(w);
      end
    end
    vic_way = (|inv_vec) ? inv_way : req_vw_r;
  end

  assign slot_free    = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE);

  sacrr_ram #(.WIDTH(32), .AW(DADDR_BITS)) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    req_wr_nxt   = req_wr_r;
    req_addr_nxt = req_addr_r;
    req_wd_nxt   = req_wd_r;
    req_wm_nxt   = req_wm_r;
    req_vw_nxt   = req_vw_r;
    pend_nxt     = pend_r;
    fill_idx_nxt = fill_idx_r;
    line_nxt     = line_r;
    base_nxt     = base_r;
    widx_nxt     = widx_r;
    blk_fill_nxt = blk_fill_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    valid_nxt    = valid_r;
    dirty_nxt    = dirty_r;

    tag_re   = 1'b0;
    tag_rset = in_addr[BLOCK_BITS +: SET_BITS];
    tag_we   = 1'b0;
    tag_wway = vic_way;

    ram_we    = 1'b0;
    ram_waddr = {line_r, fill_idx_r};
    ram_wdata = in_req.pay.fill_data;
    ram_re    = 1'b0;
    ram_raddr = {line_r, req_word};

    emit     = 1'b0;
    emit_pay = '{kind: KIND_READ, hit: 1'b0, address: req_addr_r, data: 32'd0,
                 last: 1'b0, hit_total: hit_cnt_r, miss_total: miss_cnt_r};

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          if ((in_req.pay.op == OP_READ || in_req.pay.op == OP_WRITE) && !pend_r) begin
            req_wr_nxt   = (in_req.pay.op == OP_WRITE);
            req_addr_nxt = in_addr;
            req_wd_nxt   = in_req.pay.write_data;
            req_wm_nxt   = in_req.pay.write_mask;
            req_vw_nxt   = in_req.pay.victim_way[WAY_BITS-1:0];
            tag_re       = 1'b1;
            state_nxt    = S_TAG;
          end else if (in_req.pay.op == OP_FILL && pend_r) begin
            // Fill words land in word order; the last one completes the line.
            ram_we       = 1'b1;
            fill_idx_nxt = fill_idx_r + 1'b1;
            if (fill_idx_r == WORD_BITS'(NWORDS - 1)) begin
              pend_nxt                      = 1'b0;
              valid_nxt[line_r[LINE_BITS-1 -: SET_BITS]][line_r[WAY_BITS-1:0]] = 1'b1;
              dirty_nxt[line_r[LINE_BITS-1 -: SET_BITS]][line_r[WAY_BITS-1:0]] = 1'b0;
              state_nxt                     = S_FRD;
            end
          end
        end
      end

      S_TAG: begin
        if (|hit_vec) begin
          if (hit_cnt_r != '1) begin
            hit_cnt_nxt = hit_cnt_r + 32'd1;
          end
          line_nxt  = {req_set, hit_way};
          ram_re    = 1'b1;
          ram_raddr = {req_set, hit_way, req_word};
          state_nxt = S_HIT;
        end else begin
          if (miss_cnt_r != '1) begin
            miss_cnt_nxt = miss_cnt_r + 32'd1;
          end
          line_nxt     = {req_set, vic_way};
          base_nxt     = 32'({tag_row_r[vic_way], req_set, {BLOCK_BITS{1'b0}}});
          widx_nxt     = '0;
          blk_fill_nxt = 1'b0;
          fill_idx_nxt = '0;
          pend_nxt     = 1'b1;
          tag_we       = 1'b1;
          valid_nxt[req_set][vic_way] = 1'b0;
          dirty_nxt[req_set][vic_way] = 1'b0;
          state_nxt = (valid_r[req_set][vic_way] && dirty_r[req_set][vic_way]) ?
                      S_EVRD : S_FETCH;
        end
      end

      S_HIT: begin
        if (slot_free) begin
          emit              = 1'b1;
          emit_pay.hit      = 1'b1;
          emit_pay.last     = 1'b1;
          if (req_wr_r) begin
            emit_pay.kind = KIND_WRITE;
            ram_we        = 1'b1;
            ram_waddr     = {line_r, req_word};
            ram_wdata     = merge_word(ram_rdata, req_wd_r, req_wm_r);
            dirty_nxt[line_r[LINE_BITS-1 -: SET_BITS]][line_r[WAY_BITS-1:0]] = 1'b1;
          end else begin
            emit_pay.kind = KIND_READ;
            emit_pay.data = ram_rdata;
          end
          state_nxt = S_IDLE;
        end
      end

      S_EVRD: begin
        ram_re    = 1'b1;
        ram_raddr = {line_r, widx_r};
        state_nxt = S_EVOUT;
      end

      S_EVOUT: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_pay.kind    = KIND_MEMW;
          emit_pay.address = base_r | 32'({widx_r, 2'b00});
          emit_pay.data    = ram_rdata;
          widx_nxt         = widx_r + 1'b1;
          if (widx_r == WORD_BITS'(NWORDS - 1)) begin
            state_nxt = blk_fill_r ? S_WDONE : S_FETCH;
          end else begin
            state_nxt = S_EVRD;
          end
        end
      end

      S_FETCH: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_pay.kind    = KIND_FETCH;
          emit_pay.address = req_addr_r & ~BLOCK_MASK;
          emit_pay.last    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = {line_r, req_word};
        state_nxt = S_FOUT;
      end

      S_FOUT: begin
        if (req_wr_r) begin
          // Merge the write, then write the whole block through.
          ram_we       = 1'b1;
          ram_waddr    = {line_r, req_word};
          ram_wdata    = merge_word(ram_rdata, req_wd_r, req_wm_r);
          base_nxt     = req_addr_r & ~BLOCK_MASK;
          widx_nxt     = '0;
          blk_fill_nxt = 1'b1;
          state_nxt    = S_EVRD;
        end else if (slot_free) begin
          emit          = 1'b1;
          emit_pay.kind = KIND_READ;
          emit_pay.data = ram_rdata;
          emit_pay.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_WDONE: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_pay.kind = KIND_WRITE;
          emit_pay.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit || (out_valid_r && !out_rsp.ready);
    out_nxt       = emit ? emit_pay : out_r;
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.pay   = out_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[req_set][tag_wway] <= req_tag;
    end
    if (tag_re) begin
      for (int w = 0; w < NWAYS; w++) begin
        tag_row_r[w] <= tag_mem[tag_rset][w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      fill_idx_r  <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      blk_fill_r  <= 1'b0;
      widx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      fill_idx_r  <= fill_idx_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      blk_fill_r  <= blk_fill_nxt;
      widx_r      <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_wr_r   <= req_wr_nxt;
    req_addr_r <= req_addr_nxt;
    req_wd_r   <= req_wd_nxt;
    req_wm_r   <= req_wm_nxt;
    req_vw_r   <= req_vw_nxt;
    line_r     <= line_nxt;
    base_r     <= base_nxt;
    out_r      <= out_nxt;
  end

`ifndef ASSERT_OFF
  // A block can never be present in two ways of its set.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAG) |-> $onehot0(hit_vec))
    else $error("tag matches in more than one way");

  // Fill progress only exists while a fill is pending.
  a_fill_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_idx_r != '0) |-> pend_r)
    else $error("fill index moved with no pending fill");

  // The pending line stays invalid until its last fill word arrives.
  a_pend_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !valid_r[line_r[LINE_BITS-1 -: SET_BITS]][line_r[WAY_BITS-1:0]])
    else $error("pending line marked valid");

  // Totals never decrease.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (hit_cnt_r >= $past(hit_cnt_r)) && (miss_cnt_r >= $past(miss_cnt_r)))
    else $error("access total went down");
`endif

endmodule

// File: tb/sv/sacrr_cache_checker.sv
// Scoreboard for the cache: predicts results from accepted requests and checks them.
module sacrr_cache_checker import sacrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sacrr_in_if  in_mon,
  sacrr_out_if out_mon,
  output int   mism_count,
  output int   rsp_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLINES = NSETS * NWAYS;

  logic                line_ok    [NLINES];
  logic                line_mod   [NLINES];
  logic [TAG_BITS-1:0] line_tagv  [NLINES];
  logic [31:0]         line_data  [NLINES*NWORDS];

  logic        miss_open;
  logic [1:0]  miss_op;
  logic [31:0] miss_addr, miss_wdata, miss_wmask;
  int          miss_line;
  int          fill_cnt;
  logic [31:0] hits_seen, misses_seen;

  out_pay_t expected_rsp_q[$];

  assign rsp_waiting = expected_rsp_q.size();

  // Appends one expected result carrying the current totals.
  task automatic push_rsp(input logic [1:0] k, input logic h, input logic [31:0] ad,
                          input logic [31:0] d);
    out_pay_t r;
    r.kind = k;
    r.hit = h;
    r.address = ad;
    r.data = d;
    r.last = 1'b0;
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    expected_rsp_q.push_back(r);
  endtask

  // Every word of a line leaves as a memory write, in word order.
  task automatic push_block(input int ln);
    logic [31:0] base;
    base = {line_tagv[ln], 6'(ln >> WAY_BITS), 6'b0};
    for (int w = 0; w < NWORDS; w++)
      push_rsp(KIND_MEMW, 1'b0, base + 32'(w << 2), line_data[ln*NWORDS + w]);
  endtask

  task automatic cache_predict(input in_pay_t p);
    logic [31:0] a;
    int set_i, wrd, ln, n0;
    logic [TAG_BITS-1:0] tg;
    bit found;
    n0 = expected_rsp_q.size();
    if (p.op == OP_READ || p.op == OP_WRITE) begin
      if (miss_open) return;  // an access during a pending miss is dropped
      a = p.addr & ADDR_MASK & ~WORD_ALIGN;
      set_i = a[BLOCK_BITS +: SET_BITS];
      tg = a[31 -: TAG_BITS];
      wrd = a[2 +: WORD_BITS];
      found = 0;
      ln = 0;
      for (int w = 0; w < NWAYS; w++)
        if (!found && line_ok[set_i*NWAYS + w] && line_tagv[set_i*NWAYS + w] == tg) begin
          found = 1;
          ln = set_i*NWAYS + w;
        end
      if (found) begin
        if (hits_seen != '1) hits_seen++;
        if (p.op == OP_READ) begin
          push_rsp(KIND_READ, 1'b1, a, line_data[ln*NWORDS + wrd]);
        end else begin
          line_data[ln*NWORDS + wrd] = (line_data[ln*NWORDS + wrd] & ~p.write_mask) |
                                       (p.write_data & p.write_mask);
          line_mod[ln] = 1'b1;
          push_rsp(KIND_WRITE, 1'b1, a, 32'd0);
        end
      end else begin
        if (misses_seen != '1) misses_seen++;
        for (int w = 0; w < NWAYS; w++)
          if (!found && !line_ok[set_i*NWAYS + w]) begin
            found = 1;
            ln = set_i*NWAYS + w;
          end
        if (!found) ln = set_i*NWAYS + p.victim_way;
        if (line_ok[ln] && line_mod[ln]) push_block(ln);
        line_ok[ln] = 1'b0;
        line_mod[ln] = 1'b0;
        line_tagv[ln] = tg;
        push_rsp(KIND_FETCH, 1'b0, a & ~BLOCK_MASK, 32'd0);
        miss_open = 1'b1;
        miss_op = p.op;
        miss_addr = a;
        miss_wdata = p.write_data;
        miss_wmask = p.write_mask;
        miss_line = ln;
        fill_cnt = 0;
      end
    end else if (p.op == OP_FILL) begin
      if (!miss_open) return;
      line_data[miss_line*NWORDS + fill_cnt] = p.fill_data;
      fill_cnt++;
      if (fill_cnt < NWORDS) return;
      fill_cnt = 0;
      miss_open = 1'b0;
      line_ok[miss_line] = 1'b1;
      line_mod[miss_line] = 1'b0;
      wrd = miss_addr[2 +: WORD_BITS];
      if (miss_op == OP_READ) begin
        push_rsp(KIND_READ, 1'b0, miss_addr, line_data[miss_line*NWORDS + wrd]);
      end else begin
        line_data[miss_line*NWORDS + wrd] = (line_data[miss_line*NWORDS + wrd] &
                                             ~miss_wmask) | (miss_wdata & miss_wmask);
        push_block(miss_line);
        push_rsp(KIND_WRITE, 1'b0, miss_addr, 32'd0);
      end
    end
    if (expected_rsp_q.size() > n0) expected_rsp_q[$].last = 1'b1;
  endtask

  task automatic check_rsp(input out_pay_t got);
    out_pay_t exp_r;
    if (expected_rsp_q.size() == 0) begin
      $error("unexpected result: kind %0d address %h", got.kind, got.address);
      mism_count++;
      return;
    end
    exp_r = expected_rsp_q.pop_front();
    if (got.kind !== exp_r.kind) begin
      $error("kind: expected %0d, actual %0d", exp_r.kind, got.kind); mism_count++;
    end
    if (got.hit !== exp_r.hit) begin
      $error("hit: expected %0d, actual %0d", exp_r.hit, got.hit); mism_count++;
    end
    if (got.address !== exp_r.address) begin
      $error("address: expected %h, actual %h", exp_r.address, got.address); mism_count++;
    end
    if (got.data !== exp_r.data) begin
      $error("data: expected %h, actual %h", exp_r.data, got.data); mism_count++;
    end
    if (got.last !== exp_r.last) begin
      $error("last: expected %0d, actual %0d", exp_r.last, got.last); mism_count++;
    end
    if (got.hit_total !== exp_r.hit_total) begin
      $error("hit_total: expected %0d, actual %0d", exp_r.hit_total, got.hit_total);
      mism_count++;
    end
    if (got.miss_total !== exp_r.miss_total) begin
      $error("miss_total: expected %0d, actual %0d", exp_r.miss_total, got.miss_total);
      mism_count++;
    end
  endtask

  initial begin
    mism_count = 0;
    miss_open = 1'b0;
    fill_cnt = 0;
    hits_seen = '0;
    misses_seen = '0;
    for (int i = 0; i < NLINES; i++) begin
      line_ok[i] = 1'b0;
      line_mod[i] = 1'b0;
      line_tagv[i] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) cache_predict(in_mon.pay);
      if (out_mon.valid && out_mon.ready) check_rsp(out_mon.pay);
    end
  end
endmodule

// File: tb/sv/set_assoc_cache_random_replace_core_tb.sv
// Top of the cache testbench: clock, reset, request stimulus and the verdict.
module set_assoc_cache_random_replace_core_tb;
  import sacrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sacrr_in_if  req_ch ();
  sacrr_out_if rsp_ch ();

  int  mism_count;
  int  rsp_waiting;
  bit  calm = 0;        // set for the closing stretch: no idling on either side
  int  runs_done = 0;   // results accepted with last set
  bit  last_was_fetch = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  always #1 clk = ~clk;

  set_assoc_cache_random_replace_core uut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source)
  );

  sacrr_cache_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(req_ch), .out_mon(rsp_ch),
    .mism_count(mism_count), .rsp_waiting(rsp_waiting)
  );

  // The result side stalls in random bursts until the calm stretch.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Tracks the end of each result run so the sender knows whether a miss began.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.pay.last) begin
      runs_done <= runs_done + 1;
      last_was_fetch <= (rsp_ch.pay.kind == KIND_FETCH);
    end
  end

  // The watchdog ends a run that has stopped moving requests and results.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one request, after an optional idle burst, and returns at its acceptance.
  task automatic send_req(input in_pay_t p);
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.pay <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic in_pay_t make_req(input logic [1:0] op, input logic [31:0] addr,
                                       input logic [31:0] wd, input logic [31:0] wm,
                                       input logic [1:0] vw);
    in_pay_t p;
    p.op = op;
    p.addr = addr;
    p.write_data = wd;
    p.write_mask = wm;
    p.victim_way = vw;
    p.fill_data = $urandom();
    return p;
  endfunction

  // Streams one block of fill words; now and then an access is slipped in,
  // which the cache must drop because a miss is still pending.
  task automatic feed_block(input bit extremes);
    in_pay_t p;
    for (int i = 0; i < NWORDS; i++) begin
      if (!extremes && $urandom_range(0, 11) == 0)
        send_req(make_req($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                          $urandom_range(0, 3)));
      p = make_req(OP_FILL, $urandom(), $urandom(), $urandom(), $urandom_range(0, 3));
      if (extremes) p.fill_data = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
      send_req(p);
    end
  endtask

  // One complete access: the request, its result run, and on a miss the fill
  // together with the result run that the last fill word causes.
  task automatic run_access(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] wd, input logic [31:0] wm,
                            input logic [1:0] vw, input bit extremes);
    int seen;
    seen = runs_done;
    send_req(make_req(op, addr, wd, wm, vw));
    req_ch.valid <= 1'b0;
    while (runs_done == seen) @(posedge clk);
    if (last_was_fetch) begin
      seen = runs_done;
      feed_block(extremes);
      req_ch.valid <= 1'b0;
      while (runs_done == seen) @(posedge clk);
    end
  endtask

  // Addresses mostly hit the blocks of set 0 left resident by the directed part;
  // now and then a random address forces a miss with a random victim.
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 19) == 0) return $urandom();
    return {20'($urandom_range(1, 4)), 6'd0, 4'($urandom()), 2'($urandom())};
  endfunction

  initial begin
    logic [31:0] a;
    req_ch.valid = 1'b0;
    req_ch.pay = '0;
    rsp_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: stray fill and op 3 with nothing pending are ignored.
    send_req(make_req(OP_FILL, 32'h0, 32'h0, 32'h0, 2'd0));
    send_req(make_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
    run_access(OP_READ, 32'h0, 32'h0, 32'h0, 2'd0, 1'b1);                   // read miss
    run_access(OP_READ, 32'h0000_0003, 32'h0, 32'h0, 2'd0, 1'b0);           // read hit
    run_access(OP_WRITE, 32'h4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 1'b0);  // full-mask hit
    run_access(OP_WRITE, 32'h8, 32'hFFFF_FFFF, 32'h0, 2'd0, 1'b0);          // empty mask
    run_access(OP_READ, 32'h4, 32'h0, 32'h0, 2'd0, 1'b0);
    run_access(OP_WRITE, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 2'd3, 1'b1); // write miss
    run_access(OP_READ, 32'hFFFF_FFFC, 32'h0, 32'h0, 2'd3, 1'b0);
    // Fill every way of set 0, then a write miss with victim way 0 evicts the dirty
    // first block.
    for (int t = 1; t < 4; t++)
      run_access(OP_READ, {20'(t), 12'h0}, 32'h0, 32'h0, 2'd0, 1'b0);
    run_access(OP_WRITE, {20'd4, 12'h0}, $urandom(), $urandom(), 2'd0, 1'b0);
    run_access(OP_WRITE, {20'd4, 12'h10}, $urandom(), $urandom(), 2'd0, 1'b0);

    // Random part; the sender waits out every result once before going on.
    for (int i = 0; i < 20; i++) begin
      if (i == 16) calm = 1;
      if (i == 8) begin
        req_ch.valid <= 1'b0;
        while (rsp_waiting != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0: send_req(make_req(2'd3, $urandom(), $urandom(), $urandom(), $urandom_range(0, 3)));
        1: send_req(make_req(OP_FILL, $urandom(), $urandom(), $urandom(),
                             $urandom_range(0, 3)));
        default: begin
          a = pick_addr();
          run_access($urandom_range(0, 1), a, $urandom(),
                     ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom(),
                     $urandom_range(0, 3), 1'b0);
        end
      endcase
    end

    req_ch.valid <= 1'b0;
    while (rsp_waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mism_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
